// ===== rtl/pmsfp_pkg.sv =====
// Shared constants and types for the particulate sensor frame parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pmsfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 32;
  localparam int unsigned WORD_COUNT_DEF  = 15;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned SUM_W   = 16;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h42;

  // Word record handed from the front to the back through the queue.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
    logic               last;
    logic [SUM_W-1:0]   sum;
  } word_rec_t;

endpackage

// ===== rtl/pmsfp_byte_if.sv =====
// Byte channel carrying one received serial byte per beat.
// Depends on pmsfp_pkg.
`timescale 1ns / 1ps

interface pmsfp_byte_if;
  import pmsfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/pmsfp_word_if.sv =====
// Word channel carrying one parsed frame word per beat.
// Depends on pmsfp_pkg.
`timescale 1ns / 1ps

interface pmsfp_word_if;
  import pmsfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  word_value;
  logic               last_word;
  logic               checksum_ok;

  modport source (output valid, output word_index, output word_value,
                  output last_word, output checksum_ok, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input last_word, input checksum_ok, output ready);
endinterface

// ===== rtl/pmsfp_front.sv =====
// Front end: hunts for the start byte, tracks the byte position, keeps the
// running sum and assembles byte pairs into word records. Depends on pmsfp_pkg.
`timescale 1ns / 1ps

module pmsfp_front #(
  parameter int unsigned FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEF,
  parameter int unsigned WORD_COUNT  = pmsfp_pkg::WORD_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pmsfp_byte_if.sink          byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output pmsfp_pkg::word_rec_t q_rec_o
);
  import pmsfp_pkg::*;

  localparam int unsigned POS_MAX =
      (FRAME_BYTES > 2 * WORD_COUNT + 1) ? FRAME_BYTES : 2 * WORD_COUNT + 1;
  localparam int unsigned POS_W = $clog2(POS_MAX + 1);

  localparam logic [POS_W-1:0] SUM_END    = POS_W'(2 * WORD_COUNT);
  localparam logic [POS_W-1:0] LAST_IDX   = POS_W'(WORD_COUNT - 1);
  localparam logic [POS_W-1:0] FRAME_END  = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] FIRST_LOW  = POS_W'(3);
  localparam logic [POS_W-1:0] FIRST_HIGH = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

  logic               in_frame_q, in_frame_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [BYTE_W-1:0]  high_q, high_d;

  logic               accept;
  logic               high_slot;
  logic               low_slot;
  logic [POS_W-1:0]   idx_full;
  logic [POS_W-1:0]   pos_inc;
  logic               is_last;

  // A byte is taken whenever the queue has room, so bytes that make no word
  // never wait on the back end beyond a full queue.
  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  assign high_slot = !pos_q[0] && (pos_q >= FIRST_HIGH);
  assign low_slot  = pos_q[0] && (pos_q >= FIRST_LOW);
  assign idx_full  = (pos_q - FIRST_LOW) >> 1;
  assign is_last   = (idx_full == LAST_IDX);
  assign pos_inc   = pos_q + POS_ONE;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    high_d     = high_q;
    q_push_o   = 1'b0;

    q_rec_o.index = idx_full[INDEX_W-1:0];
    q_rec_o.value = {high_q, byte_i.rx_byte};
    q_rec_o.last  = is_last;
    q_rec_o.sum   = sum_q;

    if (accept) begin
      if (!in_frame_q) begin
        if (byte_i.rx_byte == START_BYTE) begin
          in_frame_d = 1'b1;
          pos_d      = POS_ONE;
          sum_d      = SUM_W'(START_BYTE);
          high_d     = '0;
        end
      end else begin
        if (pos_q < SUM_END) begin
          sum_d = sum_q + SUM_W'(byte_i.rx_byte);
        end
        q_rec_o.sum = sum_d;
        if (high_slot) begin
          high_d = byte_i.rx_byte;
        end
        q_push_o = low_slot;
        if (low_slot && is_last) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else if (pos_inc >= FRAME_END) begin
          // Frame too short to reach the checksum word: dropped silently.
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
      high_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      high_q     <= high_d;
    end
  end

endmodule

// ===== rtl/pmsfp_queue.sv =====
// Two-entry queue of word records between the front and the back end.
// Depends on pmsfp_pkg.
`timescale 1ns / 1ps

module pmsfp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pmsfp_pkg::word_rec_t rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output pmsfp_pkg::word_rec_t rec_o
);
  import pmsfp_pkg::*;

  word_rec_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/pmsfp_back.sv =====
// Back end: checks the checksum word against the running sum and holds each
// result in an output register until the sink takes it. Depends on pmsfp_pkg.
`timescale 1ns / 1ps

module pmsfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  pmsfp_pkg::word_rec_t q_rec_i,
  output logic                 q_pop_o,
  pmsfp_word_if.source         word_o
);
  import pmsfp_pkg::*;

  logic               valid_q;
  logic [INDEX_W-1:0] index_q;
  logic [WORD_W-1:0]  value_q;
  logic               last_q;
  logic               ok_q;

  assign q_pop_o = q_valid_i && (!valid_q || word_o.ready);

  assign word_o.valid       = valid_q;
  assign word_o.word_index  = index_q;
  assign word_o.word_value  = value_q;
  assign word_o.last_word   = last_q;
  assign word_o.checksum_ok = ok_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      index_q <= q_rec_i.index;
      value_q <= q_rec_i.value;
      last_q  <= q_rec_i.last;
      ok_q    <= q_rec_i.last && (q_rec_i.sum == q_rec_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (word_o.ready) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== rtl/pm_sensor_frame_parser_core.sv =====
// Top level of the particulate sensor frame parser: front end, word queue and
// back end. Depends on pmsfp_pkg, pmsfp_byte_if, pmsfp_word_if and submodules.
//
//   Port     Dir  Beat carries
//   byte_i   in   rx_byte (one received serial byte)
//   word_o   out  word_index, word_value, last_word, checksum_ok
//
// One byte is taken per cycle while the queue is not full; a word passes from
// the front end through the queue to the output register that drives word_o.
// byte_i.ready drops only while the two-entry queue is full.
// A stall on word_o backs up into the queue; the front end keeps taking bytes
// until the queue fills. Reset puts the parser back to hunting for a start byte.
`timescale 1ns / 1ps

module pm_sensor_frame_parser_core #(
  parameter int unsigned FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEF,
  parameter int unsigned WORD_COUNT  = pmsfp_pkg::WORD_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmsfp_byte_if.sink    byte_i,
  pmsfp_word_if.source  word_o
);
  import pmsfp_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  word_rec_t q_in_rec;
  word_rec_t q_out_rec;

  pmsfp_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .WORD_COUNT  (WORD_COUNT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_rec_o  (q_in_rec)
  );

  pmsfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_in_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_out_rec)
  );

  pmsfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_rec_i   (q_out_rec),
    .q_pop_o   (q_pop),
    .word_o    (word_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("word queue written while full");

  a_ok_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_o.valid && word_o.checksum_ok) |-> word_o.last_word)
    else $error("checksum_ok set on a word that is not the last");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !word_o.valid) |=> word_o.valid)
    else $error("queued word not moved to the output register");
`endif

endmodule
